>>> hdl/pud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pud_pkg: shared types and constants of the percent URL decoder
// Character codes, register map, held-escape states and the queue entry that
// carries decoded bytes from the front end to the result sequencer.
// ----------------------------------------------------------------------------
package pud_pkg;

	// Character codes
	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_0       = 8'h30;
	localparam logic [7:0] CHAR_9       = 8'h39;
	localparam logic [7:0] CHAR_LA      = 8'h61;
	localparam logic [7:0] CHAR_LF      = 8'h66;
	localparam logic [7:0] CHAR_UA      = 8'h41;
	localparam logic [7:0] CHAR_UF      = 8'h46;
	localparam logic [7:0] HEX_ALPHA_OFS = 8'd10;

	// Register map (register index is byte address / 4)
	localparam int          PADDR_W              = 3;
	localparam logic        REG_MAX_OUTPUT_BYTES = 1'b0;
	localparam logic [15:0] MAX_OUTPUT_RESET     = 16'd255;

	// Pending bytes of an unfinished escape
	typedef enum logic [1:0] {
		HELD_NONE,      // nothing pending
		HELD_PCT,       // '%' pending
		HELD_PCT_BYTE   // '%' and one more byte pending
	} pud_held_t;

	// One accepted byte's worth of decoded output
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      count;   // decoded bytes kept, 0..3
		logic            last;    // string ends with this word
		logic            trunc;   // truncation flag after this word
	} pud_entry_t;

	// Hex digit decode: {ok, nibble}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		begin
			v = 8'd0;
			if (c >= CHAR_0 && c <= CHAR_9) begin
				v = c - CHAR_0;
				hex_nibble = {1'b1, v[3:0]};
			end else if (c >= CHAR_LA && c <= CHAR_LF) begin
				v = c - CHAR_LA + HEX_ALPHA_OFS;
				hex_nibble = {1'b1, v[3:0]};
			end else if (c >= CHAR_UA && c <= CHAR_UF) begin
				v = c - CHAR_UA + HEX_ALPHA_OFS;
				hex_nibble = {1'b1, v[3:0]};
			end else begin
				hex_nibble = 5'd0;
			end
		end
	endfunction

	// Plain byte mapping: '+' becomes a space, all else passes
	function automatic logic [7:0] plain_map(input logic [7:0] c);
		plain_map = (c == CHAR_PLUS) ? CHAR_SPACE : c;
	endfunction

endpackage

>>> hdl/pud_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pud_chan_if: valid/ready channels of the percent URL decoder
// Input channel carries raw string bytes, output channel carries results.
// ----------------------------------------------------------------------------
interface pud_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pud_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       string_end;
	logic       truncated;

	modport source (output valid, output out_byte, output byte_valid, output run_last,
		output string_end, output truncated, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input run_last,
		input string_end, input truncated, output ready);
endinterface

>>> hdl/pud_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pud_front: byte classifier and escape decoder
// Accepts one raw byte per cycle while the queue is not full, resolves percent
// escapes against the held bytes, applies the output capacity and pushes one
// queue entry per word that keeps results or ends a string.
// ----------------------------------------------------------------------------
module pud_front
	import pud_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	pud_in_if.sink           in_ch,
	input  logic [15:0]      max_output_bytes,
	input  logic             q_full,
	output logic             q_push,
	output pud_entry_t       q_entry
);

	pud_held_t   held_q, held_d;
	logic [7:0]  held1_q, held1_d;
	logic [15:0] emitted_q;
	logic        overflow_q;

	logic        accept;
	logic [7:0]  b;
	logic        last;
	logic [4:0]  hx1, hx2;
	logic [2:0][7:0] pb;
	logic [1:0]  np;
	logic [16:0] room;
	logic [1:0]  keep;
	logic        ovf_d;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;
	assign b           = in_ch.in_byte;
	assign last        = in_ch.in_last;
	assign hx1         = hex_nibble(held1_q);
	assign hx2         = hex_nibble(b);

	// Next held escape state
	always_comb begin
		held_d  = HELD_NONE;
		held1_d = held1_q;
		unique case (held_q)
			HELD_NONE: begin
				if (b == CHAR_PERCENT && !last) held_d = HELD_PCT;
			end
			HELD_PCT: begin
				if (!last) begin
					held_d  = HELD_PCT_BYTE;
					held1_d = b;
				end
			end
			HELD_PCT_BYTE: begin
				if (!(hx1[4] && hx2[4]) && !last) begin
					if (held1_q == CHAR_PERCENT) begin
						held_d  = HELD_PCT_BYTE;
						held1_d = b;
					end else if (b == CHAR_PERCENT) begin
						held_d = HELD_PCT;
					end
				end
			end
			default: held_d = HELD_NONE;
		endcase
	end

	// Decoded bytes produced by this word, before capacity
	always_comb begin
		pb = '0;
		np = 2'd0;
		unique case (held_q)
			HELD_NONE: begin
				if (!(b == CHAR_PERCENT && !last)) begin
					pb[0] = plain_map(b);
					np    = 2'd1;
				end
			end
			HELD_PCT: begin
				if (last) begin
					pb[0] = CHAR_PERCENT;
					pb[1] = plain_map(b);
					np    = 2'd2;
				end
			end
			HELD_PCT_BYTE: begin
				if (hx1[4] && hx2[4]) begin
					pb[0] = {hx1[3:0], hx2[3:0]};
					np    = 2'd1;
				end else if (held1_q == CHAR_PERCENT) begin
					pb[0] = CHAR_PERCENT;
					if (last) begin
						pb[1] = CHAR_PERCENT;
						pb[2] = plain_map(b);
						np    = 2'd3;
					end else begin
						np    = 2'd1;
					end
				end else begin
					pb[0] = CHAR_PERCENT;
					pb[1] = plain_map(held1_q);
					if (b == CHAR_PERCENT && !last) begin
						np    = 2'd2;
					end else begin
						pb[2] = plain_map(b);
						np    = 2'd3;
					end
				end
			end
			default: np = 2'd0;
		endcase
	end

	// Clip to the remaining capacity of the string
	always_comb begin
		room = {1'b0, max_output_bytes} - {1'b0, emitted_q};
		if (emitted_q >= max_output_bytes) begin
			keep = 2'd0;
		end else if (room >= {15'd0, np}) begin
			keep = np;
		end else begin
			keep = room[1:0];
		end
		ovf_d = overflow_q || (keep != np);
	end

	assign q_push        = accept && (keep != 2'd0 || last);
	assign q_entry.bytes = pb;
	assign q_entry.count = keep;
	assign q_entry.last  = last;
	assign q_entry.trunc = ovf_d;

	// Advance string state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= HELD_NONE;
			emitted_q  <= 16'd0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			held_q <= held_d;
			if (last) begin
				emitted_q  <= 16'd0;
				overflow_q <= 1'b0;
			end else begin
				emitted_q  <= emitted_q + {14'd0, keep};
				overflow_q <= ovf_d;
			end
		end
	end

	// Held byte after the '%' carries no reset
	always_ff @(posedge clk) begin
		if (accept) held1_q <= held1_d;
	end

endmodule

>>> hdl/pud_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pud_queue: entry queue between front end and result sequencer
// Small circular buffer with a fill count; head entry is read in place.
// ----------------------------------------------------------------------------
module pud_queue
	import pud_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pud_entry_t push_entry,
	input  logic       pop,
	output pud_entry_t head,
	output logic       full,
	output logic       empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	pud_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

endmodule

>>> hdl/pud_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pud_back: result sequencer
// Walks the head queue entry one decoded byte per cycle, while the receiver
// keeps up, into the output register, marking the end of each word and of each string.
// ----------------------------------------------------------------------------
module pud_back
	import pud_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  pud_entry_t head,
	input  logic       q_empty,
	output logic       q_pop,
	pud_out_if.source  out_ch
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       run_last_q;
	logic       string_end_q;
	logic       truncated_q;

	logic       load;
	logic       fin;
	logic       has_byte;

	assign load     = !out_valid_q || out_ch.ready;
	assign has_byte = (head.count != 2'd0);
	assign fin      = !has_byte || (idx_q == head.count - 2'd1);
	assign q_pop    = load && !q_empty && fin;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_byte   = out_byte_q;
	assign out_ch.byte_valid = byte_valid_q;
	assign out_ch.run_last   = run_last_q;
	assign out_ch.string_end = string_end_q;
	assign out_ch.truncated  = truncated_q;

	// Step through the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) idx_q <= fin ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			out_byte_q   <= has_byte ? head.bytes[idx_q] : 8'd0;
			byte_valid_q <= has_byte;
			run_last_q   <= fin;
			string_end_q <= fin && head.last;
			truncated_q  <= head.trunc;
		end
	end

endmodule

>>> hdl/percent_url_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_url_decoder_core: streaming form-urlencoded percent decoder
// Decodes %XX escapes and '+' one raw byte per word, with capacity limit.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one raw byte per word, in_last marks the final byte of a
//          string. out_ch gives one result per decoded byte; run_last marks
//          the last result of an input word, string_end the last of a string.
//          A string that ends with nothing emitted gives one result with
//          byte_valid low.
//   APB    register 0 (byte address 0) is max_output_bytes, reset 255.
//          Write it only while the decoder is idle.
// Path: an accepted byte is stored as a queue entry, then loaded into the
//   output register.
// Throughput: one word per cycle while each word yields at most one result
//   and the receiver is ready; a word that flushes a failed escape yields up
//   to three results, emitted one at a time. The queue absorbs these bursts.
// Stall: a stalled receiver holds the output register; the queue fills and
//   in_ch.ready drops only when it is full.
// Reset: asynchronous; clears escape state, counters, queue and output valid.
// ----------------------------------------------------------------------------
module percent_url_decoder_core
	import pud_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	pud_in_if.sink             in_ch,
	pud_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [15:0] max_output_bytes_q;
	logic        q_push, q_pop, q_full, q_empty;
	pud_entry_t  q_entry, q_head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_OUTPUT_BYTES) ? {16'd0, max_output_bytes_q} : 32'd0;

	// Capture register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_output_bytes_q <= MAX_OUTPUT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_MAX_OUTPUT_BYTES) begin
			max_output_bytes_q <= pwdata[15:0];
		end
	end

	pud_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_ch            (in_ch),
		.max_output_bytes (max_output_bytes_q),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_entry          (q_entry)
	);

	pud_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty)
	);

	pud_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule
